// ===== rtl/stt_pkg.sv =====
// shared types, constants and helper functions for the source text tokenizer
package stt_pkg;

    localparam int HOLD_BYTES  = 6;
    localparam int LINE_BITS   = 24;
    localparam int ACC_W       = 32;
    localparam int MAX_RESULTS = 8;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W   = RES_IDX_W + 1;
    localparam int HOLD_CNT_W  = $clog2(HOLD_BYTES + 1);

    // scanner modes
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_OPER,
        MODE_STRING,
        MODE_ESCAPE,
        MODE_COMMENT,
        MODE_ERROR
    } scan_mode_t;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_BIN,
        BASE_OCT,
        BASE_HEX
    } num_base_t;

    // event codes
    localparam logic [1:0] EV_TEXT  = 2'd0;
    localparam logic [1:0] EV_DONE  = 2'd1;
    localparam logic [1:0] EV_ERROR = 2'd2;

    // token kinds
    localparam logic [2:0] KIND_KEYWORD = 3'd0;
    localparam logic [2:0] KIND_IDENT   = 3'd1;
    localparam logic [2:0] KIND_INT     = 3'd2;
    localparam logic [2:0] KIND_PUNCT   = 3'd3;
    localparam logic [2:0] KIND_OPER    = 3'd4;
    localparam logic [2:0] KIND_STRING  = 3'd5;
    localparam logic [2:0] KIND_END     = 3'd6;

    // keyword ids
    localparam logic [1:0] KW_NONE   = 2'd0;
    localparam logic [1:0] KW_FN     = 2'd1;
    localparam logic [1:0] KW_RETURN = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_BAD_INT    = 2'd0;
    localparam logic [1:0] ERR_BAD_ESCAPE = 2'd1;
    localparam logic [1:0] ERR_UNCLOSED   = 2'd2;
    localparam logic [1:0] ERR_BAD_CHAR   = 2'd3;

    localparam logic [7:0]       BYTE_NONE = 8'h00;
    localparam logic [ACC_W-1:0] VAL_NONE  = '0;

    // characters
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_USCORE = 8'h5f;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_UP_Z   = 8'h5a;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_O      = 8'h6f;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_Z      = 8'h7a;

    localparam logic [HOLD_CNT_W-1:0] KW_FN_LEN  = HOLD_CNT_W'(2);
    localparam logic [HOLD_CNT_W-1:0] KW_RET_LEN = HOLD_CNT_W'(6);

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_source;
    } in_item_t;

    typedef struct packed {
        logic [1:0]           event_res;
        logic [2:0]           token_kind;
        logic [1:0]           keyword_id;
        logic [7:0]           text_byte;
        logic [ACC_W-1:0]     int_value;
        logic [LINE_BITS-1:0] line_number;
        logic [1:0]           error_code;
        logic                 last_of_run;
    } out_item_t;

    // scanner state; held identifier bytes are always a keyword prefix,
    // so only the keyword choice and the count are kept
    typedef struct packed {
        scan_mode_t            mode;
        logic                  hold_is_ret;
        logic [HOLD_CNT_W-1:0] hold_cnt;
        logic [ACC_W-1:0]      acc;
        num_base_t             base;
        logic                  first_digit;
        logic [LINE_BITS-1:0]  line;
    } scan_state_t;

    typedef struct packed {
        out_item_t [MAX_RESULTS-1:0] items;
        logic [RES_CNT_W-1:0]        cnt;
    } burst_t;

    localparam scan_state_t STATE_RESET = '{
        mode:        MODE_IDLE,
        hold_is_ret: 1'b0,
        hold_cnt:    '0,
        acc:         '0,
        base:        BASE_DEC,
        first_digit: 1'b0,
        line:        LINE_BITS'(1)
    };

    function automatic logic is_ident_start(input logic [7:0] c);
        return (c >= CH_A && c <= CH_Z) || (c >= CH_UP_A && c <= CH_UP_Z) || c == CH_USCORE;
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c == 8'h28 || c == 8'h29 || c == 8'h7b || c == 8'h7d ||
               c == 8'h5b || c == 8'h5d || c == 8'h3b || c == 8'h2c;
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return c == 8'h2b || c == 8'h2d || c == 8'h2a || c == 8'h2f || c == 8'h25 ||
               c == 8'h3d || c == 8'h21 || c == 8'h3c || c == 8'h3e;
    endfunction

    // byte idx of "fn" or "return"
    function automatic logic [7:0] kw_byte(input logic is_ret,
                                           input logic [HOLD_CNT_W-1:0] idx);
        logic [7:0] b;
        if (!is_ret) begin
            b = (idx == '0) ? CH_F : CH_N;
        end
        else begin
            unique case (idx)
                HOLD_CNT_W'(0): b = CH_R;
                HOLD_CNT_W'(1): b = CH_E;
                HOLD_CNT_W'(2): b = CH_T;
                HOLD_CNT_W'(3): b = CH_U;
                HOLD_CNT_W'(4): b = CH_R;
                default:        b = CH_N;
            endcase
        end
        return b;
    endfunction

    // does byte c keep the held bytes a keyword prefix
    function automatic logic kw_extends(input logic is_ret,
                                        input logic [HOLD_CNT_W-1:0] cnt,
                                        input logic [7:0] c);
        logic ok;
        ok = 1'b0;
        if (cnt < HOLD_CNT_W'(HOLD_BYTES)) begin
            if (!is_ret) begin
                ok = (cnt == HOLD_CNT_W'(1)) && (c == CH_N);
            end
            else begin
                ok = (cnt < KW_RET_LEN) && (c == kw_byte(1'b1, cnt));
            end
        end
        return ok;
    endfunction

    // digit value, 16 when not a digit
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] d;
        if (is_decimal(c)) begin
            d = 5'(c - CH_0);
        end
        else if (c >= CH_A && c <= CH_F) begin
            d = 5'(c - CH_A) + 5'd10;
        end
        else if (c >= CH_UP_A && c <= CH_UP_F) begin
            d = 5'(c - CH_UP_A) + 5'd10;
        end
        else begin
            d = 5'd16;
        end
        return d;
    endfunction

    function automatic logic digit_fits(input num_base_t base, input logic [4:0] d);
        logic ok;
        unique case (base)
            BASE_DEC: ok = d < 5'd10;
            BASE_BIN: ok = d < 5'd2;
            BASE_OCT: ok = d < 5'd8;
            BASE_HEX: ok = d < 5'd16;
        endcase
        return ok;
    endfunction

    // acc * radix + d, wrapping
    function automatic logic [ACC_W-1:0] next_acc(input logic [ACC_W-1:0] acc,
                                                  input num_base_t base,
                                                  input logic [4:0] d);
        logic [ACC_W-1:0] scaled;
        unique case (base)
            BASE_DEC: scaled = (acc << 3) + (acc << 1);
            BASE_BIN: scaled = acc << 1;
            BASE_OCT: scaled = acc << 3;
            BASE_HEX: scaled = acc << 4;
        endcase
        return scaled + ACC_W'(d);
    endfunction

    function automatic logic [LINE_BITS-1:0] line_bump(input logic [LINE_BITS-1:0] line);
        return (line == '1) ? line : line + 1'b1;
    endfunction

    function automatic logic [RES_CNT_W-1:0] hold_to_cnt(input logic [HOLD_CNT_W-1:0] h);
        return RES_CNT_W'(h);
    endfunction

    function automatic out_item_t make_item(input logic [1:0] ev,
                                            input logic [2:0] kind,
                                            input logic [1:0] kw,
                                            input logic [7:0] b,
                                            input logic [ACC_W-1:0] val,
                                            input logic [1:0] err,
                                            input logic [LINE_BITS-1:0] line);
        out_item_t r;
        r.event_res   = ev;
        r.token_kind  = kind;
        r.keyword_id  = kw;
        r.text_byte   = b;
        r.int_value   = val;
        r.line_number = line;
        r.error_code  = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/stt_step.sv =====
// one scanner step: results of one input beat and the next scanner state
module stt_step (
    input  stt_pkg::scan_state_t st,
    input  stt_pkg::in_item_t    item,
    output stt_pkg::scan_state_t st_next,
    output stt_pkg::burst_t      burst
);

    stt_pkg::out_item_t [stt_pkg::MAX_RESULTS-1:0] items;
    logic [stt_pkg::RES_CNT_W-1:0] n;
    logic [7:0] c;
    logic [4:0] dval;
    logic       do_close;
    logic       do_idle;
    stt_pkg::scan_state_t nxt;

    always_comb
    begin
        nxt      = st;
        items    = '0;
        n        = '0;
        do_close = 1'b0;
        do_idle  = 1'b0;
        c        = item.char_in;
        dval     = stt_pkg::digit_value(c);

        if (item.end_of_source)
        begin
            unique case (st.mode)
                stt_pkg::MODE_STRING:
                begin
                    items[n[stt_pkg::RES_IDX_W-1:0]] = stt_pkg::make_item(stt_pkg::EV_ERROR,
                        stt_pkg::KIND_KEYWORD, stt_pkg::KW_NONE, stt_pkg::BYTE_NONE,
                        stt_pkg::VAL_NONE, stt_pkg::ERR_UNCLOSED, st.line);
                    n = n + 1'b1;
                end
                stt_pkg::MODE_ESCAPE:
                begin
                    items[n[stt_pkg::RES_IDX_W-1:0]] = stt_pkg::make_item(stt_pkg::EV_ERROR,
                        stt_pkg::KIND_KEYWORD, stt_pkg::KW_NONE, stt_pkg::BYTE_NONE,
                        stt_pkg::VAL_NONE, stt_pkg::ERR_BAD_ESCAPE, st.line);
                    n = n + 1'b1;
                end
                stt_pkg::MODE_IDENT, stt_pkg::MODE_NUMBER, stt_pkg::MODE_OPER:
                    do_close = 1'b1;
                default: ;
            endcase
        end
        else
        begin
            unique case (st.mode)
                stt_pkg::MODE_ERROR:
                begin
                    if (c == stt_pkg::CH_NL)
                        nxt.line = stt_pkg::line_bump(st.line);
                end
                stt_pkg::MODE_COMMENT:
                begin
                    if (c == stt_pkg::CH_NL)
                    begin
                        nxt.line = stt_pkg::line_bump(st.line);
                        nxt.mode = stt_pkg::MODE_IDLE;
                    end
                end
                stt_pkg::MODE_STRING:
                begin
                    if (c == stt_pkg::CH_BSLASH)
                    begin
                        nxt.mode = stt_pkg::MODE_ESCAPE;
                    end
                    else if (c == stt_pkg::CH_NL)
                    begin
                        items[n[stt_pkg::RES_IDX_W-1:0]] = stt_pkg::make_item(stt_pkg::EV_ERROR,
                            stt_pkg::KIND_KEYWORD, stt_pkg::KW_NONE, c,
                            stt_pkg::VAL_NONE, stt_pkg::ERR_UNCLOSED, st.line);
                        n = n + 1'b1;
                        nxt.mode = stt_pkg::MODE_ERROR;
                        nxt.line = stt_pkg::line_bump(st.line);
                    end
                    else if (c == stt_pkg::CH_QUOTE)
                    begin
                        items[n[stt_pkg::RES_IDX_W-1:0]] = stt_pkg::make_item(stt_pkg::EV_DONE,
                            stt_pkg::KIND_STRING, stt_pkg::KW_NONE, stt_pkg::BYTE_NONE,
                            stt_pkg::VAL_NONE, stt_pkg::ERR_NONE, st.line);
                        n = n + 1'b1;
                        nxt.mode = stt_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        items[n[stt_pkg::RES_IDX_W-1:0]] = stt_pkg::make_item(stt_pkg::EV_TEXT,
                            stt_pkg::KIND_STRING, stt_pkg::KW_NONE, c,
                            stt_pkg::VAL_NONE, stt_pkg::ERR_NONE, st.line);
                        n = n + 1'b1;
                    end
                end
                stt_pkg::MODE_ESCAPE:
                begin
                    if (c == stt_pkg::CH_N || c == stt_pkg::CH_T ||
                        c == stt_pkg::CH_BSLASH || c == stt_pkg::CH_QUOTE)
                    begin
                        items[n[stt_pkg::RES_IDX_W-1:0]] = stt_pkg::make_item(stt_pkg::EV_TEXT,
                            stt_pkg::KIND_STRING, stt_pkg::KW_NONE,
                            (c == stt_pkg::CH_N) ? stt_pkg::CH_NL :
                            (c == stt_pkg::CH_T) ? stt_pkg::CH_TAB : c,
                            stt_pkg::VAL_NONE, stt_pkg::ERR_NONE, st.line);
                        n = n + 1'b1;
                        nxt.mode = stt_pkg::MODE_STRING;
                    end
                    else
                    begin
                        items[n[stt_pkg::RES_IDX_W-1:0]] = stt_pkg::make_item(stt_pkg::EV_ERROR,
                            stt_pkg::KIND_KEYWORD, stt_pkg::KW_NONE, c,
                            stt_pkg::VAL_NONE, stt_pkg::ERR_BAD_ESCAPE, st.line);
                        n = n + 1'b1;
                        nxt.mode = stt_pkg::MODE_ERROR;
                        if (c == stt_pkg::CH_NL)
                            nxt.line = stt_pkg::line_bump(st.line);
                    end
                end
                stt_pkg::MODE_IDENT:
                begin
                    if (stt_pkg::is_ident_start(c) || stt_pkg::is_decimal(c))
                    begin
                        if (st.hold_cnt != '0 && stt_pkg::kw_extends(st.hold_is_ret, st.hold_cnt, c))
                        begin
                            nxt.hold_cnt = st.hold_cnt + 1'b1;
                        end
                        else
                        begin
                            // held prefix goes out first, from slot zero
                            for (int k = 0; k < stt_pkg::HOLD_BYTES; k++)
                            begin
                                if (k < stt_pkg::MAX_RESULTS && k < int'(st.hold_cnt))
                                    items[k] = stt_pkg::make_item(stt_pkg::EV_TEXT,
                                        stt_pkg::KIND_IDENT, stt_pkg::KW_NONE,
                                        stt_pkg::kw_byte(st.hold_is_ret,
                                                         stt_pkg::HOLD_CNT_W'(k)),
                                        stt_pkg::VAL_NONE, stt_pkg::ERR_NONE, st.line);
                            end
                            n = stt_pkg::hold_to_cnt(st.hold_cnt);
                            nxt.hold_cnt = '0;
                            items[n[stt_pkg::RES_IDX_W-1:0]] = stt_pkg::make_item(
                                stt_pkg::EV_TEXT, stt_pkg::KIND_IDENT, stt_pkg::KW_NONE, c,
                                stt_pkg::VAL_NONE, stt_pkg::ERR_NONE, st.line);
                            n = n + 1'b1;
                        end
                    end
                    else
                    begin
                        do_close = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                stt_pkg::MODE_NUMBER:
                begin
                    if (stt_pkg::is_ident_start(c) || stt_pkg::is_decimal(c))
                    begin
                        if (st.first_digit && st.acc == '0 && st.base == stt_pkg::BASE_DEC &&
                            (c == stt_pkg::CH_B || c == stt_pkg::CH_O || c == stt_pkg::CH_X))
                        begin
                            nxt.base = (c == stt_pkg::CH_B) ? stt_pkg::BASE_BIN :
                                       (c == stt_pkg::CH_O) ? stt_pkg::BASE_OCT :
                                                              stt_pkg::BASE_HEX;
                            nxt.first_digit = 1'b0;
                        end
                        else if (!stt_pkg::digit_fits(st.base, dval))
                        begin
                            items[n[stt_pkg::RES_IDX_W-1:0]] = stt_pkg::make_item(
                                stt_pkg::EV_ERROR, stt_pkg::KIND_KEYWORD, stt_pkg::KW_NONE, c,
                                stt_pkg::VAL_NONE, stt_pkg::ERR_BAD_INT, st.line);
                            n = n + 1'b1;
                            nxt.mode = stt_pkg::MODE_ERROR;
                        end
                        else
                        begin
                            nxt.acc = stt_pkg::next_acc(st.acc, st.base, dval);
                            nxt.first_digit = 1'b0;
                        end
                    end
                    else
                    begin
                        do_close = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                stt_pkg::MODE_OPER:
                begin
                    if (stt_pkg::is_oper(c))
                    begin
                        items[n[stt_pkg::RES_IDX_W-1:0]] = stt_pkg::make_item(stt_pkg::EV_TEXT,
                            stt_pkg::KIND_OPER, stt_pkg::KW_NONE, c,
                            stt_pkg::VAL_NONE, stt_pkg::ERR_NONE, st.line);
                        n = n + 1'b1;
                    end
                    else
                    begin
                        do_close = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                stt_pkg::MODE_IDLE:
                    do_idle = 1'b1;
            endcase
        end

        // finish the open token
        if (do_close)
        begin
            if (st.mode == stt_pkg::MODE_IDENT)
            begin
                if (!st.hold_is_ret && st.hold_cnt == stt_pkg::KW_FN_LEN)
                begin
                    items[n[stt_pkg::RES_IDX_W-1:0]] = stt_pkg::make_item(stt_pkg::EV_DONE,
                        stt_pkg::KIND_KEYWORD, stt_pkg::KW_FN, stt_pkg::BYTE_NONE,
                        stt_pkg::VAL_NONE, stt_pkg::ERR_NONE, st.line);
                    n = n + 1'b1;
                end
                else if (st.hold_is_ret && st.hold_cnt == stt_pkg::KW_RET_LEN)
                begin
                    items[n[stt_pkg::RES_IDX_W-1:0]] = stt_pkg::make_item(stt_pkg::EV_DONE,
                        stt_pkg::KIND_KEYWORD, stt_pkg::KW_RETURN, stt_pkg::BYTE_NONE,
                        stt_pkg::VAL_NONE, stt_pkg::ERR_NONE, st.line);
                    n = n + 1'b1;
                end
                else
                begin
                    for (int k = 0; k < stt_pkg::HOLD_BYTES; k++)
                    begin
                        if (k < stt_pkg::MAX_RESULTS && k < int'(st.hold_cnt))
                            items[k] = stt_pkg::make_item(stt_pkg::EV_TEXT,
                                stt_pkg::KIND_IDENT, stt_pkg::KW_NONE,
                                stt_pkg::kw_byte(st.hold_is_ret, stt_pkg::HOLD_CNT_W'(k)),
                                stt_pkg::VAL_NONE, stt_pkg::ERR_NONE, st.line);
                    end
                    n = stt_pkg::hold_to_cnt(st.hold_cnt);
                    items[n[stt_pkg::RES_IDX_W-1:0]] = stt_pkg::make_item(stt_pkg::EV_DONE,
                        stt_pkg::KIND_IDENT, stt_pkg::KW_NONE, stt_pkg::BYTE_NONE,
                        stt_pkg::VAL_NONE, stt_pkg::ERR_NONE, st.line);
                    n = n + 1'b1;
                end
            end
            else if (st.mode == stt_pkg::MODE_NUMBER)
            begin
                items[n[stt_pkg::RES_IDX_W-1:0]] = stt_pkg::make_item(stt_pkg::EV_DONE,
                    stt_pkg::KIND_INT, stt_pkg::KW_NONE, stt_pkg::BYTE_NONE,
                    st.acc, stt_pkg::ERR_NONE, st.line);
                n = n + 1'b1;
            end
            else
            begin
                items[n[stt_pkg::RES_IDX_W-1:0]] = stt_pkg::make_item(stt_pkg::EV_DONE,
                    stt_pkg::KIND_OPER, stt_pkg::KW_NONE, stt_pkg::BYTE_NONE,
                    stt_pkg::VAL_NONE, stt_pkg::ERR_NONE, st.line);
                n = n + 1'b1;
            end
            nxt.mode     = stt_pkg::MODE_IDLE;
            nxt.hold_cnt = '0;
        end

        // byte seen between tokens
        if (do_idle)
        begin
            nxt.mode = stt_pkg::MODE_IDLE;
            if (c == stt_pkg::CH_SPACE || c == stt_pkg::CH_TAB || c == stt_pkg::CH_NL)
            begin
                if (c == stt_pkg::CH_NL)
                    nxt.line = stt_pkg::line_bump(st.line);
            end
            else if (stt_pkg::is_ident_start(c))
            begin
                nxt.mode = stt_pkg::MODE_IDENT;
                nxt.hold_cnt = '0;
                if (c == stt_pkg::CH_F || c == stt_pkg::CH_R)
                begin
                    nxt.hold_cnt    = stt_pkg::HOLD_CNT_W'(1);
                    nxt.hold_is_ret = (c == stt_pkg::CH_R);
                end
                else
                begin
                    items[n[stt_pkg::RES_IDX_W-1:0]] = stt_pkg::make_item(stt_pkg::EV_TEXT,
                        stt_pkg::KIND_IDENT, stt_pkg::KW_NONE, c,
                        stt_pkg::VAL_NONE, stt_pkg::ERR_NONE, st.line);
                    n = n + 1'b1;
                end
            end
            else if (stt_pkg::is_decimal(c))
            begin
                nxt.mode        = stt_pkg::MODE_NUMBER;
                nxt.acc         = stt_pkg::next_acc('0, stt_pkg::BASE_DEC, dval);
                nxt.base        = stt_pkg::BASE_DEC;
                nxt.first_digit = 1'b1;
            end
            else if (stt_pkg::is_punct(c))
            begin
                items[n[stt_pkg::RES_IDX_W-1:0]] = stt_pkg::make_item(stt_pkg::EV_DONE,
                    stt_pkg::KIND_PUNCT, stt_pkg::KW_NONE, c,
                    stt_pkg::VAL_NONE, stt_pkg::ERR_NONE, st.line);
                n = n + 1'b1;
            end
            else if (stt_pkg::is_oper(c))
            begin
                nxt.mode = stt_pkg::MODE_OPER;
                items[n[stt_pkg::RES_IDX_W-1:0]] = stt_pkg::make_item(stt_pkg::EV_TEXT,
                    stt_pkg::KIND_OPER, stt_pkg::KW_NONE, c,
                    stt_pkg::VAL_NONE, stt_pkg::ERR_NONE, st.line);
                n = n + 1'b1;
            end
            else if (c == stt_pkg::CH_QUOTE)
            begin
                nxt.mode = stt_pkg::MODE_STRING;
            end
            else if (c == stt_pkg::CH_HASH)
            begin
                nxt.mode = stt_pkg::MODE_COMMENT;
            end
            else
            begin
                items[n[stt_pkg::RES_IDX_W-1:0]] = stt_pkg::make_item(stt_pkg::EV_ERROR,
                    stt_pkg::KIND_KEYWORD, stt_pkg::KW_NONE, c,
                    stt_pkg::VAL_NONE, stt_pkg::ERR_BAD_CHAR, st.line);
                n = n + 1'b1;
                nxt.mode = stt_pkg::MODE_ERROR;
            end
        end

        // end mark always closes with an end token and a fresh state
        if (item.end_of_source)
        begin
            items[n[stt_pkg::RES_IDX_W-1:0]] = stt_pkg::make_item(stt_pkg::EV_DONE,
                stt_pkg::KIND_END, stt_pkg::KW_NONE, stt_pkg::BYTE_NONE,
                stt_pkg::VAL_NONE, stt_pkg::ERR_NONE, st.line);
            n = n + 1'b1;
            nxt = stt_pkg::STATE_RESET;
        end
    end

    assign st_next     = nxt;
    assign burst.items = items;
    assign burst.cnt   = n;

endmodule

// ===== rtl/source_text_tokenizer.sv =====
// top level of the source text tokenizer: input register, scanner step, result burst buffer
// path: an accepted beat waits in the input register until the burst buffer is free, then
//   it is scanned and its results are registered in the burst buffer
// throughput: one input beat per cycle while each beat yields at most one result and
//   out_stall is low; a beat's k results hold the buffer until taken, one per unstalled cycle
// reset: asynchronous, clears the input valid flag, burst count, read index and scanner state
module source_text_tokenizer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  stt_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output stt_pkg::out_item_t out_data
);

    // input register
    logic                 in_vld_reg;
    logic                 in_vld_next;
    stt_pkg::in_item_t    in_item_reg;

    // scanner state, updated once per consumed beat
    stt_pkg::scan_state_t state_reg;
    stt_pkg::scan_state_t state_next;

    // burst buffer: every result of one beat, drained one per cycle while out_stall is low
    stt_pkg::out_item_t [stt_pkg::MAX_RESULTS-1:0] items_reg;
    logic [stt_pkg::RES_CNT_W-1:0] cnt_reg;
    logic [stt_pkg::RES_CNT_W-1:0] cnt_next;
    logic [stt_pkg::RES_IDX_W-1:0] rd_reg;
    logic [stt_pkg::RES_IDX_W-1:0] rd_next;

    stt_pkg::burst_t               burst;
    logic [stt_pkg::RES_CNT_W-1:0] rd_ext;
    logic [stt_pkg::RES_CNT_W-1:0] last_idx;
    logic                          at_last;
    logic                          pop;
    logic                          buf_free;
    logic                          consume;
    logic                          take_in;

    stt_step u_step (
        .st      (state_reg),
        .item    (in_item_reg),
        .st_next (state_next),
        .burst   (burst)
    );

    assign rd_ext   = {1'b0, rd_reg};
    assign last_idx = cnt_reg - 1'b1;
    assign at_last  = (rd_ext == last_idx);

    // a result beat leaves the buffer
    assign pop      = (cnt_reg != '0) && !out_stall;
    // buffer can take the next burst at this edge: empty or giving up its last entry
    assign buf_free = (cnt_reg == '0) || (pop && at_last);
    assign consume  = in_vld_reg && buf_free;

    // input register holds its beat until the scanner takes it
    assign in_stall = in_vld_reg && !buf_free;
    assign take_in  = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (take_in)
            in_vld_next = 1'b1;
        else if (consume)
            in_vld_next = 1'b0;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        if (consume)
        begin
            // beats with no result leave the buffer empty
            cnt_next = burst.cnt;
            rd_next  = '0;
        end
        else if (pop)
        begin
            if (at_last)
            begin
                cnt_next = '0;
                rd_next  = '0;
            end
            else
            begin
                rd_next = rd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            cnt_reg    <= '0;
            rd_reg     <= '0;
            state_reg  <= stt_pkg::STATE_RESET;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            cnt_reg    <= cnt_next;
            rd_reg     <= rd_next;
            if (consume)
                state_reg <= state_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take_in)
            in_item_reg <= in_data;
        if (consume)
            items_reg <= burst.items;
    end

    // result beat straight from the buffer, last flag marks the end of the burst
    assign out_valid = (cnt_reg != '0);

    always_comb
    begin
        out_data             = items_reg[rd_reg];
        out_data.last_of_run = at_last;
    end

endmodule

// ===== test/stt_checker.sv =====
`timescale 1ns / 1ps
// scoreboard for the source text tokenizer: predicts token events per input beat and checks them
module stt_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  stt_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  stt_pkg::out_item_t out_data,
    output int                 mismatches,
    output int                 pending
);
    import stt_pkg::*;

    localparam logic [15:0] FN_TEXT  = "fn";
    localparam logic [47:0] RET_TEXT = "return";

    // lexer state
    scan_mode_t           mode;
    logic [7:0]           held [HOLD_BYTES];
    int                   held_n;
    logic [ACC_W-1:0]     acc;
    num_base_t            radix_sel;
    int                   digit_pos;
    logic [LINE_BITS-1:0] line_no;

    out_item_t step_events [MAX_RESULTS];
    int        step_n;
    out_item_t expected_tokens [$];
    out_item_t want;
    int        bad;

    function automatic void lexer_reset();
        mode      = MODE_IDLE;
        held_n    = 0;
        acc       = '0;
        radix_sel = BASE_DEC;
        digit_pos = 0;
        line_no   = LINE_BITS'(1);
    endfunction

    function automatic void add_event(input logic [1:0] ev, input logic [2:0] kind,
                                      input logic [1:0] kw, input logic [7:0] b,
                                      input logic [ACC_W-1:0] val, input logic [1:0] err);
        out_item_t r;
        r.event_res   = ev;
        r.token_kind  = kind;
        r.keyword_id  = kw;
        r.text_byte   = b;
        r.int_value   = val;
        r.line_number = line_no;
        r.error_code  = err;
        r.last_of_run = 1'b0;
        if (step_n < MAX_RESULTS)
        begin
            step_events[step_n] = r;
            step_n++;
        end
    endfunction

    function automatic void next_line();
        if (line_no != '1)
        begin
            line_no = line_no + 1'b1;
        end
    endfunction

    // kind reads as zero on errors
    function automatic void lex_fault(input logic [1:0] code, input logic [7:0] b);
        add_event(EV_ERROR, KIND_KEYWORD, KW_NONE, b, VAL_NONE, code);
        mode = MODE_ERROR;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_punc(input logic [7:0] c);
        return c == "(" || c == ")" || c == "{" || c == "}" ||
               c == "[" || c == "]" || c == ";" || c == ",";
    endfunction

    function automatic logic is_opchar(input logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" ||
               c == "=" || c == "!" || c == "<" || c == ">";
    endfunction

    // first n held bytes still spell the start of a keyword
    function automatic logic keyword_prefix(input int n);
        logic fn_ok;
        logic ret_ok;
        fn_ok  = (n <= 2);
        ret_ok = (n <= 6);
        for (int k = 0; k < n; k++)
        begin
            if (k < 2)
            begin
                if (held[k] != FN_TEXT[8*(1-k) +: 8]) fn_ok = 1'b0;
            end
            if (k < 6)
            begin
                if (held[k] != RET_TEXT[8*(5-k) +: 8]) ret_ok = 1'b0;
            end
        end
        return fn_ok || ret_ok;
    endfunction

    function automatic void flush_held();
        for (int k = 0; k < held_n; k++)
        begin
            add_event(EV_TEXT, KIND_IDENT, KW_NONE, held[k], VAL_NONE, ERR_NONE);
        end
        held_n = 0;
    endfunction

    function automatic void close_open();
        logic [1:0] kw;
        kw = KW_NONE;
        case (mode)
            MODE_IDENT:
            begin
                if (held_n == 2 && held[0] == FN_TEXT[15:8] && held[1] == FN_TEXT[7:0])
                    kw = KW_FN;
                else if (held_n == 6 && keyword_prefix(6))
                    kw = KW_RETURN;
                if (kw != KW_NONE)
                begin
                    held_n = 0;
                    add_event(EV_DONE, KIND_KEYWORD, kw, BYTE_NONE, VAL_NONE, ERR_NONE);
                end
                else
                begin
                    flush_held();
                    add_event(EV_DONE, KIND_IDENT, KW_NONE, BYTE_NONE, VAL_NONE, ERR_NONE);
                end
            end
            MODE_NUMBER: add_event(EV_DONE, KIND_INT, KW_NONE, BYTE_NONE, acc, ERR_NONE);
            MODE_OPER:   add_event(EV_DONE, KIND_OPER, KW_NONE, BYTE_NONE, VAL_NONE, ERR_NONE);
            default:     ;
        endcase
        mode = MODE_IDLE;
    endfunction

    function automatic void number_byte(input logic [7:0] c);
        int r;
        int d;
        case (radix_sel)
            BASE_BIN: r = 2;
            BASE_OCT: r = 8;
            BASE_HEX: r = 16;
            default:  r = 10;
        endcase
        // radix prefix only right after a lone leading zero
        if (digit_pos == 1 && acc == '0 && radix_sel == BASE_DEC &&
            (c == "b" || c == "o" || c == "x"))
        begin
            if (c == "b")
                radix_sel = BASE_BIN;
            else if (c == "o")
                radix_sel = BASE_OCT;
            else
                radix_sel = BASE_HEX;
            digit_pos = 2;
        end
        else
        begin
            if (is_num(c))
                d = c - "0";
            else if (c >= "a" && c <= "f")
                d = c - "a" + 10;
            else if (c >= "A" && c <= "F")
                d = c - "A" + 10;
            else
                d = 16;
            if (d >= r)
            begin
                lex_fault(ERR_BAD_INT, c);
            end
            else
            begin
                acc       = acc * ACC_W'(r) + ACC_W'(d);
                digit_pos = 2;
            end
        end
    endfunction

    function automatic void ident_byte(input logic [7:0] c);
        logic keep;
        keep = 1'b0;
        if (held_n > 0)
        begin
            if (held_n < HOLD_BYTES)
            begin
                held[held_n] = c;
                if (keyword_prefix(held_n + 1))
                begin
                    held_n++;
                    keep = 1'b1;
                end
            end
            if (!keep) flush_held();
        end
        if (!keep) add_event(EV_TEXT, KIND_IDENT, KW_NONE, c, VAL_NONE, ERR_NONE);
    endfunction

    function automatic void idle_byte(input logic [7:0] c);
        if (c == CH_SPACE || c == CH_TAB || c == CH_NL)
        begin
            if (c == CH_NL) next_line();
        end
        else if (is_alpha(c))
        begin
            mode   = MODE_IDENT;
            held_n = 0;
            if (c == "f" || c == "r")
            begin
                held[0] = c;
                held_n  = 1;
            end
            else
            begin
                add_event(EV_TEXT, KIND_IDENT, KW_NONE, c, VAL_NONE, ERR_NONE);
            end
        end
        else if (is_num(c))
        begin
            mode      = MODE_NUMBER;
            acc       = ACC_W'(c - "0");
            radix_sel = BASE_DEC;
            digit_pos = 1;
        end
        else if (is_punc(c))
            add_event(EV_DONE, KIND_PUNCT, KW_NONE, c, VAL_NONE, ERR_NONE);
        else if (is_opchar(c))
        begin
            mode = MODE_OPER;
            add_event(EV_TEXT, KIND_OPER, KW_NONE, c, VAL_NONE, ERR_NONE);
        end
        else if (c == CH_QUOTE)
            mode = MODE_STRING;
        else if (c == CH_HASH)
            mode = MODE_COMMENT;
        else
            lex_fault(ERR_BAD_CHAR, c);
    endfunction

    function automatic void take_byte(input logic [7:0] c);
        logic restart;
        restart = 1'b0;
        case (mode)
            MODE_ERROR:
            begin
                if (c == CH_NL) next_line();
            end
            MODE_COMMENT:
            begin
                if (c == CH_NL)
                begin
                    next_line();
                    mode = MODE_IDLE;
                end
            end
            MODE_STRING:
            begin
                if (c == CH_BSLASH)
                    mode = MODE_ESCAPE;
                else if (c == CH_NL)
                begin
                    lex_fault(ERR_UNCLOSED, c);
                    next_line();
                end
                else if (c == CH_QUOTE)
                begin
                    add_event(EV_DONE, KIND_STRING, KW_NONE, BYTE_NONE, VAL_NONE, ERR_NONE);
                    mode = MODE_IDLE;
                end
                else
                    add_event(EV_TEXT, KIND_STRING, KW_NONE, c, VAL_NONE, ERR_NONE);
            end
            MODE_ESCAPE:
            begin
                if (c == "n" || c == "t" || c == CH_BSLASH || c == CH_QUOTE)
                begin
                    add_event(EV_TEXT, KIND_STRING, KW_NONE,
                              (c == "n") ? CH_NL : (c == "t") ? CH_TAB : c,
                              VAL_NONE, ERR_NONE);
                    mode = MODE_STRING;
                end
                else
                begin
                    lex_fault(ERR_BAD_ESCAPE, c);
                    if (c == CH_NL) next_line();
                end
            end
            MODE_IDENT:
            begin
                if (is_alpha(c) || is_num(c))
                    ident_byte(c);
                else
                begin
                    close_open();
                    restart = 1'b1;
                end
            end
            MODE_NUMBER:
            begin
                if (is_alpha(c) || is_num(c))
                    number_byte(c);
                else
                begin
                    close_open();
                    restart = 1'b1;
                end
            end
            MODE_OPER:
            begin
                if (is_opchar(c))
                    add_event(EV_TEXT, KIND_OPER, KW_NONE, c, VAL_NONE, ERR_NONE);
                else
                begin
                    close_open();
                    restart = 1'b1;
                end
            end
            default:
            begin
                mode    = MODE_IDLE;
                restart = 1'b1;
            end
        endcase
        if (restart) idle_byte(c);
    endfunction

    function automatic void lex_step(input in_item_t it);
        step_n = 0;
        if (it.end_of_source)
        begin
            if (mode == MODE_STRING)
                lex_fault(ERR_UNCLOSED, BYTE_NONE);
            else if (mode == MODE_ESCAPE)
                lex_fault(ERR_BAD_ESCAPE, BYTE_NONE);
            else if (mode != MODE_ERROR)
                close_open();
            add_event(EV_DONE, KIND_END, KW_NONE, BYTE_NONE, VAL_NONE, ERR_NONE);
            lexer_reset();
        end
        else
        begin
            take_byte(it.char_in);
        end
    endfunction

    function automatic int field_bad(input string name, input logic [ACC_W-1:0] exp_v,
                                     input logic [ACC_W-1:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t checker: %s expected %0h actual %0h", $time, name, exp_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    initial
    begin
        mismatches = 0;
        pending    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lexer_reset();
            expected_tokens.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t checker: unexpected result, expected none actual %h",
                             $time, out_data);
                    mismatches++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    bad  = field_bad("event_res", want.event_res, out_data.event_res)
                         + field_bad("token_kind", want.token_kind, out_data.token_kind)
                         + field_bad("keyword_id", want.keyword_id, out_data.keyword_id)
                         + field_bad("text_byte", want.text_byte, out_data.text_byte)
                         + field_bad("int_value", want.int_value, out_data.int_value)
                         + field_bad("line_number", want.line_number, out_data.line_number)
                         + field_bad("error_code", want.error_code, out_data.error_code)
                         + field_bad("last_of_run", want.last_of_run, out_data.last_of_run);
                    if (bad != 0) mismatches++;
                end
            end
            if (in_valid && !in_stall)
            begin
                lex_step(in_data);
                for (int k = 0; k < step_n; k++)
                begin
                    want             = step_events[k];
                    want.last_of_run = (k == step_n - 1);
                    expected_tokens.push_back(want);
                end
            end
            pending = expected_tokens.size();
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// testbench top for the source text tokenizer: source byte stimulus, receiver stalls, verdict
module tb;
    import stt_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    int mismatches;
    int pending;
    int beats_sent;   // accepted input beats so far
    int hold_left;    // cycles left in a receiver hold-off
    bit tx_gaps;      // sender idles at random
    bit rx_gaps;      // receiver stalls at random
    bit rx_hold_req;  // ask the receiver for one long hold-off

    source_text_tokenizer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    stt_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop in case the handshake hangs or results go missing
    initial
    begin
        #3_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // receiver: random stalls, or a long hold-off on request so that the
    // result buffer fills and the tokenizer has to stall its input side
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left   = 80;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= rx_gaps && ($urandom_range(99) < 36);
            end
        end
    end

    // one source beat: optional idle cycles first, then hold the beat until it is taken;
    // returns on the edge that accepted it, so the next beat can follow back to back
    task automatic feed_byte(input logic [7:0] c, input logic eos);
        in_item_t beat;
        beat.char_in       = c;
        beat.end_of_source = eos;
        if (tx_gaps)
        begin
            while ($urandom_range(99) < 36)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
    endtask

    task automatic feed_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            feed_byte(s[i], 1'b0);
        end
    endtask

    // end mark; the byte beside it is ignored, so it is random
    task automatic feed_end();
        feed_byte(8'($urandom_range(255)), 1'b1);
    endtask

    function automatic logic [7:0] rand_letter();
        int k;
        k = $urandom_range(52);
        if (k < 26)
            return CH_A + 8'(k);
        else if (k < 52)
            return CH_UP_A + 8'(k - 26);
        else
            return CH_USCORE;
    endfunction

    // one random token of source text, mostly well formed;
    // broken tokens and raw noise are followed by an end mark at once so that
    // few beats are swallowed by the error state
    task automatic feed_random_token();
        int         pick;
        int         n;
        int         k;
        logic [7:0] c;
        bit         spaced;
        bit         closed;
        string      ops;
        string      puncs;
        ops    = "+-*/%=!<>";
        puncs  = "(){}[];,";
        spaced = 1'b0;
        closed = 1'b0;
        pick   = $urandom_range(99);
        if (pick < 28)
        begin
            // identifiers, biased toward keywords and their prefixes
            case ($urandom_range(9))
                0: feed_text("fn");
                1: feed_text("return");
                2: feed_text("retur");
                3: feed_text("returned");
                4: feed_text("fn9");
                5: feed_text("r");
                6: feed_text("f_");
                default:
                begin
                    feed_byte(rand_letter(), 1'b0);
                    n = $urandom_range(6);
                    repeat (n)
                    begin
                        if ($urandom_range(1) == 0)
                            feed_byte(rand_letter(), 1'b0);
                        else
                            feed_byte(CH_0 + 8'($urandom_range(9)), 1'b0);
                    end
                end
            endcase
        end
        else if (pick < 48)
        begin
            // integers in all four bases, long enough to wrap at 32 bits
            case ($urandom_range(3))
                0:
                begin
                    feed_byte(CH_0 + 8'($urandom_range(9)), 1'b0);
                    n = $urandom_range(11);
                    repeat (n) feed_byte(CH_0 + 8'($urandom_range(9)), 1'b0);
                end
                1:
                begin
                    feed_text("0b");
                    n = $urandom_range(36);
                    repeat (n) feed_byte(CH_0 + 8'($urandom_range(1)), 1'b0);
                end
                2:
                begin
                    feed_text("0o");
                    n = $urandom_range(13);
                    repeat (n) feed_byte(CH_0 + 8'($urandom_range(7)), 1'b0);
                end
                default:
                begin
                    feed_text("0x");
                    n = $urandom_range(10);
                    repeat (n)
                    begin
                        k = $urandom_range(21);
                        if (k < 10)
                            feed_byte(CH_0 + 8'(k), 1'b0);
                        else if (k < 16)
                            feed_byte(CH_A + 8'(k - 10), 1'b0);
                        else
                            feed_byte(CH_UP_A + 8'(k - 16), 1'b0);
                    end
                end
            endcase
            // a letter right after a number would be a bad digit
            spaced = 1'b1;
        end
        else if (pick < 58)
        begin
            n = $urandom_range(1, 3);
            repeat (n) feed_byte(ops[$urandom_range(8)], 1'b0);
        end
        else if (pick < 70)
        begin
            feed_byte(puncs[$urandom_range(7)], 1'b0);
        end
        else if (pick < 81)
        begin
            // string with escapes and raw bytes of any value but the three special ones
            feed_byte(CH_QUOTE, 1'b0);
            n = $urandom_range(5);
            repeat (n)
            begin
                if ($urandom_range(3) == 0)
                begin
                    feed_byte(CH_BSLASH, 1'b0);
                    case ($urandom_range(3))
                        0: feed_byte("n", 1'b0);
                        1: feed_byte("t", 1'b0);
                        2: feed_byte(CH_BSLASH, 1'b0);
                        default: feed_byte(CH_QUOTE, 1'b0);
                    endcase
                end
                else
                begin
                    c = 8'($urandom_range(255));
                    while (c == CH_BSLASH || c == CH_QUOTE || c == CH_NL)
                        c = 8'($urandom_range(255));
                    feed_byte(c, 1'b0);
                end
            end
            feed_byte(CH_QUOTE, 1'b0);
        end
        else if (pick < 86)
        begin
            // comment up to the newline
            feed_byte(CH_HASH, 1'b0);
            n = $urandom_range(4);
            repeat (n)
            begin
                c = 8'($urandom_range(255));
                if (c == CH_NL) c = CH_SPACE;
                feed_byte(c, 1'b0);
            end
            feed_byte(CH_NL, 1'b0);
        end
        else if (pick < 94)
        begin
            // broken constructs, each one error path
            case ($urandom_range(5))
                0:
                begin
                    if ($urandom_range(1) == 0)
                    begin
                        feed_text("0b");
                        feed_byte(CH_0 + 8'($urandom_range(2, 9)), 1'b0);
                    end
                    else
                    begin
                        feed_text("12");
                        feed_byte(rand_letter(), 1'b0);
                    end
                end
                1: feed_text("\"a\n");
                2:
                begin
                    feed_text("\"\\");
                    c = ($urandom_range(3) == 0) ? CH_NL : rand_letter();
                    while (c == "n" || c == "t") c = rand_letter();
                    feed_byte(c, 1'b0);
                end
                3:
                begin
                    case ($urandom_range(8))
                        0: c = 8'h00;
                        1: c = 8'h0d;
                        2: c = "@";
                        3: c = "$";
                        4: c = ".";
                        5: c = ":";
                        6: c = "~";
                        7: c = 8'h7f;
                        default: c = 8'($urandom_range(128, 255));
                    endcase
                    feed_byte(c, 1'b0);
                end
                4: feed_text("\"ab");
                default: feed_text("\"\\");
            endcase
            feed_end();
            closed = 1'b1;
        end
        else
        begin
            // raw noise
            n = $urandom_range(1, 3);
            repeat (n) feed_byte(8'($urandom_range(255)), 1'b0);
            feed_end();
            closed = 1'b1;
        end

        if (!closed)
        begin
            if (spaced || $urandom_range(99) < 60)
            begin
                case ($urandom_range(3))
                    0: feed_byte(CH_SPACE, 1'b0);
                    1: feed_byte(CH_TAB, 1'b0);
                    default: feed_byte(CH_NL, 1'b0);
                endcase
            end
            if ($urandom_range(99) < 6) feed_end();
        end
    endtask

    initial
    begin
        int start;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        beats_sent  = 0;
        tx_gaps     = 1'b1;
        rx_gaps     = 1'b1;
        rx_hold_req = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed source: both keywords, a held prefix flushed by a digit,
        // a punctuator, hex with mixed case, an operator run, every escape, a comment
        feed_text("fn(return re9");
        feed_text(" 0xfF*=\"\\t\\\"\\\\\\n\"#x\n");
        feed_text("return");
        feed_end();
        // digit out of range for the base
        feed_text("0o8");
        feed_end();
        // newline inside a string
        feed_text("\"\n");
        feed_end();
        // unknown escape
        feed_text("\"\\q");
        feed_end();
        // invalid characters at both ends of the byte range; newlines still
        // counted while in the error state
        feed_byte(8'h00, 1'b0);
        feed_end();
        feed_byte(8'hff, 1'b0);
        feed_byte(CH_NL, 1'b0);
        feed_end();
        // end mark during an escape and inside an open string
        feed_text("\"\\");
        feed_end();
        feed_text("\"a");
        feed_end();
        // radix prefix with no digits completes as zero
        feed_text("0x");
        feed_end();

        // random source, first with idling on both sides and a long receiver hold-off
        start       = beats_sent;
        rx_hold_req = 1'b1;
        while (beats_sent - start < 60) feed_random_token();

        // a stretch at full rate on both sides
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        while (beats_sent - start < 100) feed_random_token();

        // idling again, with a second hold-off
        tx_gaps     = 1'b1;
        rx_gaps     = 1'b1;
        rx_hold_req = 1'b1;
        while (beats_sent - start < 145) feed_random_token();
        feed_end();
        in_valid <= 1'b0;

        // drain: wait for the last expected result, then allow for stray extras
        @(negedge clk);
        for (int w = 0; w < 4000 && pending != 0; w++) @(negedge clk);
        repeat (16) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
